[rtl/aes_pkg.sv]
package aes_pkg;

   localparam int unsigned BlockBits = 128;
   localparam int unsigned KeyBits   = 128;
   localparam int unsigned HalfBits  = 64;
   localparam int unsigned NumRounds = 10;

   localparam logic CsrKeyHigh = 1'b0;
   localparam logic CsrKeyLow  = 1'b1;

   function automatic logic [7:0] sbox(input logic [7:0] b);
      logic [7:0] r;
      case (b)
         8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
         8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
         8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
         8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
         8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
         8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
         8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
         8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
         8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
         8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
         8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
         8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
         8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
         8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
         8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
         8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
         8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
         8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
         8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
         8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
         8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
         8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
         8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
         8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
         8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
         8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
         8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
         8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
         8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
         8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
         8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
         8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
         8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
         8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
         8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
         8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
         8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
         8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
         8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
         8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
         8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
         8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
         8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
         8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
         8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
         8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
         8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
         8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
         8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
         8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
         8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
         8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
         8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
         8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
         8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
         8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
         8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
         8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
         8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
         8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
         8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
         8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
         8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
         8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   function automatic logic [7:0] next_rcon(input logic [7:0] rc);
      return xtime(rc);
   endfunction

   typedef struct packed {
      logic       load;
      logic       advance;
      logic       last;
   } round_ctl_type;

endpackage

[rtl/aes_round.sv]
// One AES round on the full state; the same unit serves all ten rounds.
module aes_round (
   input  logic [aes_pkg::BlockBits-1:0] state_in,
   input  logic [aes_pkg::KeyBits-1:0]   round_key,
   input  logic                          last,
   output logic [aes_pkg::BlockBits-1:0] state_out
);
   import aes_pkg::*;

   logic [7:0] s   [16];
   logic [7:0] t   [16];
   logic [7:0] m   [16];
   logic [BlockBits-1:0] mixed;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         s[i] = state_in[BlockBits-1-8*i -: 8];
      end
      // substitute and shift rows: byte r of column c comes from column c+r
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[4*c+r] = sbox(s[4*((c+r)%4)+r]);
         end
      end
      for (int c = 0; c < 4; c++) begin
         logic [7:0] all;
         all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
         m[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
         m[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
         m[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
         m[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
      end
      for (int i = 0; i < 16; i++) begin
         mixed[BlockBits-1-8*i -: 8] = last ? t[i] : m[i];
      end
      state_out = mixed ^ round_key;
   end

endmodule

[rtl/aes128_block_encrypt.sv]
// Channel | Ports                                  | Direction
// item in | start, busy, req_block_high/low        | in (busy out)
// result  | rsp_valid, rsp_cipher_high/low         | out
// config  | csr_write, csr_index, csr_data         | in
//
// An item starts with the initial key addition, then goes ten times through the
// shared round unit; the round key is stepped on the fly next to it, one per cycle.
// rsp_valid is high for one cycle after the last round; busy stays high until then.
// Reset (synchronous) clears the key to zero and returns the block to idle.
// The receiver cannot stall; results are never held.
module aes128_block_encrypt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [aes_pkg::HalfBits-1:0] req_block_high,
   input  logic [aes_pkg::HalfBits-1:0] req_block_low,
   output logic                         rsp_valid,
   output logic [aes_pkg::HalfBits-1:0] rsp_cipher_high,
   output logic [aes_pkg::HalfBits-1:0] rsp_cipher_low,
   input  logic                         csr_write,
   input  logic                         csr_index,
   input  logic [aes_pkg::HalfBits-1:0] csr_data
);
   import aes_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type           state_ff, state_in;
   logic [3:0]          round_ff, round_in;
   logic [HalfBits-1:0] key_high_ff, key_low_ff;
   logic [KeyBits-1:0]  rkey_ff, rkey_in;
   logic [7:0]          rcon_ff, rcon_in;
   logic [BlockBits-1:0] data_ff, data_in, round_out;
   logic                rsp_valid_ff, rsp_valid_in;
   round_ctl_type       ctl;
   logic [31:0]         w0, w1, w2, w3, tw;

   // next round key from the current one
   always_comb begin
      tw = sub_word({rkey_ff[23:0], rkey_ff[31:24]}) ^ {rcon_ff, 24'h0};
      w0 = rkey_ff[127:96] ^ tw;
      w1 = rkey_ff[95:64] ^ w0;
      w2 = rkey_ff[63:32] ^ w1;
      w3 = rkey_ff[31:0] ^ w2;
   end

   aes_round u_round (
      .state_in (data_ff),
      .round_key({w0, w1, w2, w3}),
      .last     (ctl.last),
      .state_out(round_out)
   );

   always_comb begin
      ctl.load    = (state_ff == ST_IDLE) && start;
      ctl.advance = (state_ff == ST_RUN);
      ctl.last    = (round_ff == 4'(NumRounds - 1));
      state_in     = state_ff;
      round_in     = round_ff;
      rkey_in      = rkey_ff;
      rcon_in      = rcon_ff;
      data_in      = data_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.load) begin
               data_in  = {req_block_high, req_block_low} ^ {key_high_ff, key_low_ff};
               rkey_in  = {key_high_ff, key_low_ff};
               rcon_in  = 8'h01;
               round_in = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            data_in  = round_out;
            rkey_in  = {w0, w1, w2, w3};
            rcon_in  = next_rcon(rcon_ff);
            round_in = round_ff + 4'd1;
            if (ctl.last) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         key_high_ff  <= '0;
         key_low_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               CsrKeyHigh: key_high_ff <= csr_data;
               CsrKeyLow:  key_low_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      rkey_ff <= rkey_in;
      rcon_ff <= rcon_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cipher_high = data_ff[BlockBits-1:HalfBits];
   assign rsp_cipher_low  = data_ff[HalfBits-1:0];

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      (ctl.advance && ctl.last) |=> (rsp_valid && !busy))
      else $error("result missing after last round");
   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> (round_ff < 4'(NumRounds)))
      else $error("round count overrun");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> (busy && round_ff == 4'd0))
      else $error("start not taken");

endmodule

[bench/aes128_cipher_checker.sv]
`timescale 1ns / 100ps

module aes128_cipher_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [aes_pkg::HalfBits-1:0] req_block_high,
   input  logic [aes_pkg::HalfBits-1:0] req_block_low,
   input  logic                         rsp_valid,
   input  logic [aes_pkg::HalfBits-1:0] rsp_cipher_high,
   input  logic [aes_pkg::HalfBits-1:0] rsp_cipher_low,
   input  logic                         csr_write,
   input  logic                         csr_index,
   input  logic [aes_pkg::HalfBits-1:0] csr_data,
   output int                           error_count,
   output int                           cipher_pending,
   output int                           cipher_seen
);
   import aes_pkg::*;

   typedef logic [7:0] byte_array_type [16];

   logic [7:0]  sub_lut [256];
   logic [63:0] key_hi_q, key_lo_q;
   logic [31:0] key_words [44];
   logic [127:0] cipher_queue [$];

   function automatic logic [7:0] gf_double(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_inv(input logic [7:0] b);
      logic [7:0] r, x, y;
      r = 8'h00;
      for (int i = 1; i < 256; i++) begin
         x = 8'h00;
         y = 8'(i);
         for (int k = 0; k < 8; k++) begin
            if (b[k]) x ^= y;
            y = gf_double(y);
         end
         if (x == 8'h01) r = 8'(i);
      end
      return r;
   endfunction

   // build the substitution table from the field inverse and the affine map
   initial begin
      logic [7:0] v, s;
      for (int i = 0; i < 256; i++) begin
         v = gf_inv(8'(i));
         s = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
             ^ {v[3:0], v[7:4]} ^ 8'h63;
         sub_lut[i] = s;
      end
   end

   task automatic expand_key();
      logic [31:0] t;
      logic [7:0]  rc;
      key_words[0] = key_hi_q[63:32];
      key_words[1] = key_hi_q[31:0];
      key_words[2] = key_lo_q[63:32];
      key_words[3] = key_lo_q[31:0];
      rc = 8'h01;
      for (int i = 4; i < 44; i++) begin
         t = key_words[i-1];
         if (i % 4 == 0) begin
            t = {t[23:0], t[31:24]};
            t = {sub_lut[t[31:24]], sub_lut[t[23:16]], sub_lut[t[15:8]], sub_lut[t[7:0]]}
                ^ {rc, 24'h0};
            rc = gf_double(rc);
         end
         key_words[i] = key_words[i-4] ^ t;
      end
   endtask

   function automatic logic [127:0] encrypt_block(input logic [127:0] plain);
      byte_array_type s, t;
      logic [7:0] a0, a1, a2, a3, all;
      for (int i = 0; i < 16; i++) s[i] = plain[127-8*i -: 8];
      for (int r = 0; r <= 10; r++) begin
         if (r > 0) begin
            for (int c = 0; c < 4; c++)
               for (int w = 0; w < 4; w++)
                  t[4*c+w] = sub_lut[s[4*((c+w)%4)+w]];
            s = t;
            if (r < 10)
               for (int c = 0; c < 4; c++) begin
                  a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                  all = a0 ^ a1 ^ a2 ^ a3;
                  s[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
                  s[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
                  s[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
                  s[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
               end
         end
         for (int c = 0; c < 4; c++)
            for (int k = 0; k < 4; k++)
               s[4*c+k] ^= key_words[4*r+c][31-8*k -: 8];
      end
      for (int i = 0; i < 16; i++) encrypt_block[127-8*i -: 8] = s[i];
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      logic [127:0] want;
      if (reset) begin
         key_hi_q = '0;
         key_lo_q = '0;
         expand_key();
         cipher_queue.delete();
         error_count = 0;
         cipher_seen = 0;
      end else begin
         if (rsp_valid) begin
            cipher_seen++;
            if (cipher_queue.size() == 0) begin
               $display("unexpected cipher item %h_%h", rsp_cipher_high, rsp_cipher_low);
               error_count++;
            end else begin
               want = cipher_queue.pop_front();
               if (rsp_cipher_high !== want[127:64])
                  report_mismatch("cipher_high", rsp_cipher_high, want[127:64]);
               if (rsp_cipher_low !== want[63:0])
                  report_mismatch("cipher_low", rsp_cipher_low, want[63:0]);
            end
         end
         if (start && !busy)
            cipher_queue.push_back(encrypt_block({req_block_high, req_block_low}));
         if (csr_write) begin
            if (csr_index == CsrKeyHigh) key_hi_q = csr_data;
            else key_lo_q = csr_data;
            expand_key();
         end
      end
      cipher_pending = cipher_queue.size();
   end
endmodule

[bench/tb_aes128_block_encrypt.sv]
`timescale 1ns / 100ps

module tb_aes128_block_encrypt;
   import aes_pkg::*;

   localparam int StallLimit = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_block_high = '0, req_block_low = '0;
   logic        rsp_valid;
   logic [63:0] rsp_cipher_high, rsp_cipher_low;
   logic        csr_write = 1'b0;
   logic        csr_index = CsrKeyHigh;
   logic [63:0] csr_data = '0;
   int          error_count, cipher_pending, cipher_seen;
   int          blocks_sent = 0, key_loads = 0, idle_cycles = 0;
   logic        calm = 1'b0;

   aes128_block_encrypt dut (.*);

   aes128_cipher_checker checker_i (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
      while (!calm && $urandom_range(99) < 16) @(negedge clock);
      start <= 1'b1;
      req_block_high <= hi;
      req_block_low <= lo;
      @(posedge clock);
      while (busy) @(posedge clock);
      blocks_sent++;
      @(negedge clock);
      start <= 1'b0;
      // leave the time step before the next item drives start again
      @(negedge clock);
   endtask

   task automatic drain();
      while (cipher_pending != 0) @(negedge clock);
      repeat (15) @(negedge clock);
   endtask

   task automatic load_key(input logic idx, input logic [63:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      key_loads++;
      @(negedge clock);
   endtask

   initial begin
      logic [63:0] pattern;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // all-zero key after reset
      send_block('0, '0);
      send_block('1, '1);
      drain();
      // FIPS-197 example key and plaintext
      load_key(CsrKeyHigh, 64'h0001020304050607);
      load_key(CsrKeyLow, 64'h08090a0b0c0d0e0f);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block('0, '1);
      send_block('1, '0);
      for (int b = 0; b < 64; b += 8) begin
         pattern = 64'h1 << b;
         send_block(pattern, ~pattern);
      end
      drain();
      load_key(CsrKeyHigh, '1);
      load_key(CsrKeyLow, '1);
      send_block('0, '0);
      send_block('1, '1);
      drain();
      // block under a half-updated key
      load_key(CsrKeyHigh, 64'h0);
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
      drain();

      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 4)
            0: load_key(CsrKeyHigh, rand64());
            1: load_key(CsrKeyLow, rand64());
            default: begin
               load_key(CsrKeyHigh, rand64());
               load_key(CsrKeyLow, rand64());
            end
         endcase
         calm = (phase == 5);
         for (int n = 0; n < 95; n++) begin
            case ($urandom_range(7))
               0: send_block('0, rand64());
               1: send_block(rand64(), '1);
               default: send_block(rand64(), rand64());
            endcase
         end
         drain();
      end
      calm = 1'b0;
      load_key(CsrKeyHigh, '0);
      load_key(CsrKeyLow, '0);
      send_block(rand64(), rand64());
      drain();

      $display("covered %0d blocks under %0d key register writes, %0d ciphertexts checked",
               blocks_sent, key_loads, cipher_seen);
      if (error_count == 0 && cipher_pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
